@@ rtl/circular_gaussian_byte_blur_macros.svh @@
// Assertion macros used by the checker file of the blur block.
`ifndef CIRCULAR_GAUSSIAN_BYTE_BLUR_MACROS_SVH
`define CIRCULAR_GAUSSIAN_BYTE_BLUR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CGBB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("blur checker: property failed");

// Next-cycle implication, disabled while reset is high.
`define CGBB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("blur checker: property failed");

`endif

@@ rtl/cgbb_pkg.sv @@
// Package with types, register codes and the tap weight selector of the blur block.
package cgbb_pkg;

  localparam int REG_COUNT = 5;
  localparam int TAP_W     = 4;
  localparam int WEIGHT_W  = 16;
  localparam int PROD_W    = 24;
  localparam int PADDR_W   = 5;

  localparam logic [2:0] REG_W01 = 3'd0;
  localparam logic [2:0] REG_W23 = 3'd1;
  localparam logic [2:0] REG_W45 = 3'd2;
  localparam logic [2:0] REG_W67 = 3'd3;
  localparam logic [2:0] REG_W89 = 3'd4;

  localparam logic [31:0] RST_W01 = 32'd815806653;
  localparam logic [31:0] RST_W23 = 32'd237379227;
  localparam logic [31:0] RST_W45 = 32'd20120782;
  localparam logic [31:0] RST_W67 = 32'd524344;
  localparam logic [31:0] RST_W89 = 32'd1;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EMIT = 1'b1;

  typedef logic [REG_COUNT-1:0][31:0] cgbb_wregs_t;

  typedef struct packed {
    logic clear;
    logic en;
  } cgbb_mac_ctl_t;

  function automatic logic [WEIGHT_W-1:0] tap_weight(cgbb_wregs_t w, logic [TAP_W-1:0] tap);
    logic [31:0] word;
    begin
      word = (tap[3:1] < 3'(REG_COUNT)) ? w[tap[3:1]] : '0;
      tap_weight = tap[0] ? word[31:16] : word[15:0];
    end
  endfunction

endpackage

@@ rtl/cgbb_regs.sv @@
// APB register file holding the five tap weight registers.
module cgbb_regs
  import cgbb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cgbb_wregs_t        weights
);

  logic [2:0] reg_index;
  logic       wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      weights[REG_W01] <= RST_W01;
      weights[REG_W23] <= RST_W23;
      weights[REG_W45] <= RST_W45;
      weights[REG_W67] <= RST_W67;
      weights[REG_W89] <= RST_W89;
    end else if (wr_en && reg_index < 3'(REG_COUNT)) begin
      weights[reg_index] <= pwdata;
    end
  end

  always_comb begin
    case (reg_index)
      REG_W01: prdata = weights[REG_W01];
      REG_W23: prdata = weights[REG_W23];
      REG_W45: prdata = weights[REG_W45];
      REG_W67: prdata = weights[REG_W67];
      REG_W89: prdata = weights[REG_W89];
      default: prdata = '0;
    endcase
  end

endmodule

@@ rtl/cgbb_store.sv @@
// Segment byte memory with one write port and one registered read port.
module cgbb_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/cgbb_mac.sv @@
// Shared multiply-accumulate unit with a registered product stage.
module cgbb_mac
  import cgbb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cgbb_mac_ctl_t       ctl,
  input  logic [WEIGHT_W-1:0] weight,
  input  logic [7:0]          data,
  output logic [PROD_W-1:0]   acc,
  output logic                busy
);

  logic [PROD_W-1:0] prod;
  logic              prod_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctl.en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod <= PROD_W'(weight * data);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + prod;
    end
  end

  assign busy = prod_valid;

endmodule

@@ rtl/circular_gaussian_byte_blur.sv @@
// Circular 1-D Gaussian blur over a stored byte segment, top level and sequencer.
// The input channel (in_valid, in_stall, func, sample_byte, load_last) carries
// two kinds of item. A load item (func 0) writes one byte into the segment
// store; load_last closes the segment. A load after a closed segment starts
// a new one, and bytes past STORE_DEPTH are dropped.
// An emit item (func 1) on a closed, non-empty segment yields one result on
// the output channel (out_valid, out_stall, blurred_byte, emit_last). Emits
// on an open or empty segment are taken and give nothing.
// An emit walks 2*TAP_COUNT byte reads through the single store read port,
// one per cycle, each feeding one multiply-accumulate, and then drains the
// two-stage read and product pipeline before the result is registered.
// in_stall stays high until the emit has finished, so the block takes no
// new item while an emit is in progress.
// A held result does not block loads or the next emit; a finished emit waits
// in its last step until the output register is free.
// The user sets the weights over the APB port while the block is idle; not enforced.
// Reset empties the segment, restores the default weights and drops any
// result; the store contents are undefined until loaded.
module circular_gaussian_byte_blur
  import cgbb_pkg::*;
#(
  parameter int STORE_DEPTH = 4096,
  parameter int TAP_COUNT   = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic [7:0]         sample_byte,
  input  logic               load_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         blurred_byte,
  output logic               emit_last
);

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int LW = $clog2(STORE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]          state;
  logic [LW-1:0]       seg_len;
  logic [AW-1:0]       emit_pos;
  logic                closed;
  logic [AW-1:0]       ahead;
  logic [AW-1:0]       behind;
  logic [TAP_W-1:0]    tap;
  logic                phase;
  logic                rd_valid;
  logic [WEIGHT_W-1:0] rd_weight;
  logic                last_pos;

  cgbb_wregs_t         weights;
  logic                accept;
  logic                do_load;
  logic                do_emit;
  logic [LW-1:0]       eff_len;
  logic                store_we;
  logic [AW-1:0]       len_m1;
  logic                issue;
  logic [AW-1:0]       raddr;
  logic [7:0]          rdata;
  logic                tap_done;
  logic                finish;
  cgbb_mac_ctl_t       mac_ctl;
  logic [PROD_W-1:0]   acc;
  logic                mac_busy;

  cgbb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .weights (weights)
  );

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign do_load  = accept && (func == FUNC_LOAD);
  assign do_emit  = accept && (func == FUNC_EMIT) && closed && (seg_len != '0);
  assign eff_len  = closed ? '0 : seg_len;
  assign store_we = do_load && (eff_len < LW'(STORE_DEPTH));
  assign len_m1   = AW'(seg_len - LW'(1));
  assign issue    = (state == ST_RUN);
  assign raddr    = phase ? behind : ahead;
  assign tap_done = phase && (tap == TAP_W'(TAP_COUNT - 1));
  assign finish   = (state == ST_DRAIN) && !rd_valid && !mac_busy
                    && (!out_valid || !out_stall);

  cgbb_store #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (eff_len[AW-1:0]),
    .wdata (sample_byte),
    .re    (issue),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign mac_ctl.clear = do_emit;
  assign mac_ctl.en    = rd_valid;

  cgbb_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mac_ctl),
    .weight (rd_weight),
    .data   (rdata),
    .acc    (acc),
    .busy   (mac_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      seg_len  <= '0;
      emit_pos <= '0;
      closed   <= 1'b0;
      rd_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (do_load) begin
            seg_len <= store_we ? eff_len + LW'(1) : eff_len;
            closed  <= load_last;
            if (load_last || closed) begin
              emit_pos <= '0;
            end
          end else if (do_emit) begin
            state    <= ST_RUN;
            emit_pos <= (emit_pos == len_m1) ? '0 : emit_pos + AW'(1);
          end
        end
        ST_RUN: begin
          if (tap_done) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (finish) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_weight <= tap_weight(weights, tap);
    if (do_emit) begin
      ahead    <= emit_pos;
      behind   <= emit_pos;
      tap      <= '0;
      phase    <= 1'b0;
      last_pos <= (emit_pos == len_m1);
    end else if (issue) begin
      phase <= !phase;
      if (phase) begin
        tap    <= tap + TAP_W'(1);
        ahead  <= (ahead == len_m1) ? '0 : ahead + AW'(1);
        behind <= (behind == '0) ? len_m1 : behind - AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      blurred_byte <= acc[23:16];
      emit_last    <= last_pos;
    end
  end

endmodule

@@ rtl/cgbb_checker.sv @@
// Port-level checker for the blur block and its bind to the top level.
`include "circular_gaussian_byte_blur_macros.svh"

module cgbb_checker
  import cgbb_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       func,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] blurred_byte,
  input logic       emit_last
);

  `CGBB_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid && $stable(blurred_byte) && $stable(emit_last))
  `CGBB_ASSERT_NOW(a_reset_clears_out, $past(rst), !out_valid)
  `CGBB_ASSERT_NEXT(a_load_no_result, in_valid && !in_stall && (func == FUNC_LOAD) && !out_valid, !out_valid)
  `CGBB_ASSERT_NOW(a_result_after_work, $rose(out_valid), $past(in_stall))

endmodule

bind circular_gaussian_byte_blur cgbb_checker u_cgbb_checker (.*);
